FILE: rtl/pid_antiwindup_servo_mix_defines.svh
// ----------------------------------------------------------------------------
// pid_antiwindup_servo_mix assertion macros
// Concurrent assertion wrappers on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef PID_ANTIWINDUP_SERVO_MIX_DEFINES_SVH
`define PID_ANTIWINDUP_SERVO_MIX_DEFINES_SVH

`ifndef ASSERT_OFF

`define PIDAW_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pidaw assertion failed");

`define PIDAW_ASSERT(label, prop) \
    `PIDAW_ASSERT_CLK(label, aclk, aresetn, prop)

`else

`define PIDAW_ASSERT_CLK(label, clk, rst_n, prop)

`define PIDAW_ASSERT(label, prop)

`endif

`endif

FILE: rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared constants, register map and configuration type of the PID block.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int FRAC_BITS_DEFAULT = 8;

    localparam int MEAS_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 31;
    localparam int DRIVE_W  = 32;
    localparam int SERVO_W  = 16;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;
    localparam int IDX_W    = 3;

    localparam int SERVO_CENTER  = 1500;
    localparam int DERIV_TRIGGER = -3;
    localparam int INTEG_TRIGGER = 75;
    localparam int INTEG_DROP    = 74;

    localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd4;

    typedef struct packed {
        logic signed [MEAS_W-1:0] target_value;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIMIT_W-1:0]       integral_limit;
    } cfg_t;

endpackage

FILE: rtl/pidaw_apb_regs.sv
// ----------------------------------------------------------------------------
// pidaw_apb_regs
// APB register file holding setpoint, gains and integral bound.
// ----------------------------------------------------------------------------
module pidaw_apb_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidaw_pkg::ADDR_W-1:0] paddr,
    input  logic [pidaw_pkg::APB_W-1:0]  pwdata,
    output logic [pidaw_pkg::APB_W-1:0]  prdata,
    output pidaw_pkg::cfg_t              cfg
);

    pidaw_pkg::cfg_t cfg_reg;
    logic [pidaw_pkg::IDX_W-1:0] reg_idx;
    logic wr_en;

    assign reg_idx = paddr[pidaw_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                pidaw_pkg::REG_TARGET: begin
                    cfg_reg.target_value <= pwdata[pidaw_pkg::MEAS_W-1:0];
                end
                pidaw_pkg::REG_GAIN_P: begin
                    cfg_reg.gain_p <= pwdata[pidaw_pkg::GAIN_W-1:0];
                end
                pidaw_pkg::REG_GAIN_I: begin
                    cfg_reg.gain_i <= pwdata[pidaw_pkg::GAIN_W-1:0];
                end
                pidaw_pkg::REG_GAIN_D: begin
                    cfg_reg.gain_d <= pwdata[pidaw_pkg::GAIN_W-1:0];
                end
                pidaw_pkg::REG_LIMIT: begin
                    cfg_reg.integral_limit <= pwdata[pidaw_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pidaw_pkg::REG_TARGET: prdata = {{(pidaw_pkg::APB_W-pidaw_pkg::MEAS_W)
                                               {cfg_reg.target_value[pidaw_pkg::MEAS_W-1]}},
                                             cfg_reg.target_value};
            pidaw_pkg::REG_GAIN_P: prdata = {{(pidaw_pkg::APB_W-pidaw_pkg::GAIN_W)
                                               {cfg_reg.gain_p[pidaw_pkg::GAIN_W-1]}},
                                             cfg_reg.gain_p};
            pidaw_pkg::REG_GAIN_I: prdata = {{(pidaw_pkg::APB_W-pidaw_pkg::GAIN_W)
                                               {cfg_reg.gain_i[pidaw_pkg::GAIN_W-1]}},
                                             cfg_reg.gain_i};
            pidaw_pkg::REG_GAIN_D: prdata = {{(pidaw_pkg::APB_W-pidaw_pkg::GAIN_W)
                                               {cfg_reg.gain_d[pidaw_pkg::GAIN_W-1]}},
                                             cfg_reg.gain_d};
            pidaw_pkg::REG_LIMIT:  prdata = {{(pidaw_pkg::APB_W-pidaw_pkg::LIMIT_W){1'b0}},
                                             cfg_reg.integral_limit};
            default:               prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/pidaw_core.sv
// ----------------------------------------------------------------------------
// pidaw_core
// Four-stage PID datapath: input, products, integral and drive, servo mix.
// ----------------------------------------------------------------------------
`include "pid_antiwindup_servo_mix_defines.svh"

module pidaw_core #(
    parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pidaw_pkg::cfg_t                      cfg,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pidaw_pkg::MEAS_W-1:0]  s_meas,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pidaw_pkg::DRIVE_W-1:0] m_drive,
    output logic signed [pidaw_pkg::SERVO_W-1:0] m_servo_a,
    output logic signed [pidaw_pkg::SERVO_W-1:0] m_servo_b
);

    localparam int ERR_W  = pidaw_pkg::MEAS_W + 1;
    localparam int DIFF_W = ERR_W + 1;
    localparam int P_W    = pidaw_pkg::GAIN_W + ERR_W;
    localparam int D_W    = pidaw_pkg::GAIN_W + DIFF_W;
    localparam int ISUM_W = P_W + 1;
    localparam int SUM_W  = D_W + 2;
    localparam int SV_W   = pidaw_pkg::DRIVE_W + 2;

    localparam logic signed [pidaw_pkg::DRIVE_W-1:0] ONE_Q =
        pidaw_pkg::DRIVE_W'(2 ** FRAC_BITS);
    localparam logic signed [pidaw_pkg::DRIVE_W-1:0] I_TRIG_Q =
        pidaw_pkg::DRIVE_W'(pidaw_pkg::INTEG_TRIGGER * (2 ** FRAC_BITS));
    localparam logic signed [pidaw_pkg::DRIVE_W-1:0] DROP_Q =
        pidaw_pkg::DRIVE_W'(pidaw_pkg::INTEG_DROP * (2 ** FRAC_BITS));
    localparam logic signed [D_W-1:0] D_TRIG_Q =
        D_W'(pidaw_pkg::DERIV_TRIGGER * (2 ** FRAC_BITS));
    localparam logic signed [SV_W-1:0] CENTER_Q =
        SV_W'(pidaw_pkg::SERVO_CENTER * (2 ** FRAC_BITS));
    localparam logic signed [SV_W-1:0] ROUND_Q = SV_W'((2 ** FRAC_BITS) - 1);
    localparam logic signed [SV_W-1:0] SERVO_MAX = SV_W'(32767);
    localparam logic signed [SV_W-1:0] SERVO_MIN = -SV_W'(32768);
    localparam logic signed [SUM_W-1:0] DRIVE_MAX = SUM_W'(64'sh7fff_ffff);
    localparam logic signed [SUM_W-1:0] DRIVE_MIN = -SUM_W'(64'sh8000_0000);

    // pipeline control
    logic v_in_reg;
    logic v_prod_reg;
    logic v_drv_reg;
    logic m_valid_reg;
    logic adv_prod;
    logic adv_drv;
    logic adv_out;

    // payload
    logic signed [pidaw_pkg::MEAS_W-1:0]  meas_reg;
    logic signed [P_W-1:0]                p_reg;
    logic signed [P_W-1:0]                ie_reg;
    logic signed [D_W-1:0]                d_reg;
    logic signed [pidaw_pkg::DRIVE_W-1:0] drive_reg;
    logic signed [pidaw_pkg::DRIVE_W-1:0] drive_out_reg;
    logic signed [pidaw_pkg::SERVO_W-1:0] servo_a_reg;
    logic signed [pidaw_pkg::SERVO_W-1:0] servo_b_reg;

    // loop state
    logic signed [pidaw_pkg::DRIVE_W-1:0] integ_acc_reg;
    logic signed [pidaw_pkg::DRIVE_W-1:0] integ_acc_next;
    logic signed [ERR_W-1:0]              prev_err_reg;

    logic signed [ERR_W-1:0]              err_val;
    logic signed [DIFF_W-1:0]             diff_val;
    logic signed [ISUM_W-1:0]             integ_sum;
    logic signed [ISUM_W-1:0]             lim_pos;
    logic signed [ISUM_W-1:0]             lim_neg;
    logic signed [pidaw_pkg::DRIVE_W-1:0] integ_clamp;
    logic                                 dec_hit;
    logic signed [SUM_W-1:0]              drive_sum;
    logic signed [pidaw_pkg::DRIVE_W-1:0] drive_next;
    logic signed [SV_W-1:0]               sa_sum;
    logic signed [SV_W-1:0]               sb_sum;

    function automatic logic signed [pidaw_pkg::SERVO_W-1:0] servo_sat(
        input logic signed [SV_W-1:0] v
    );
        logic signed [SV_W-1:0] adj;
        logic signed [SV_W-1:0] q;
        // truncate toward zero
        adj = v[SV_W-1] ? v + ROUND_Q : v;
        q   = adj >>> FRAC_BITS;
        if (q > SERVO_MAX) begin
            return SERVO_MAX[pidaw_pkg::SERVO_W-1:0];
        end else if (q < SERVO_MIN) begin
            return SERVO_MIN[pidaw_pkg::SERVO_W-1:0];
        end else begin
            return q[pidaw_pkg::SERVO_W-1:0];
        end
    endfunction

    assign adv_out  = v_drv_reg & (~m_valid_reg | m_ready);
    assign adv_drv  = v_prod_reg & (~v_drv_reg | adv_out);
    assign adv_prod = v_in_reg & (~v_prod_reg | adv_drv);
    assign s_ready  = ~v_in_reg | adv_prod;

    // stage 1: error and products
    always_comb begin
        err_val  = ERR_W'(meas_reg) - ERR_W'(cfg.target_value);
        diff_val = DIFF_W'(err_val) - DIFF_W'(prev_err_reg);
    end

    // stage 2: integral clamp, decrement rule, drive sum
    always_comb begin
        integ_sum = ISUM_W'(integ_acc_reg) + ISUM_W'(ie_reg);
        lim_pos   = $signed({{(ISUM_W-pidaw_pkg::LIMIT_W){1'b0}}, cfg.integral_limit});
        lim_neg   = -lim_pos;
        if (integ_sum > lim_pos) begin
            integ_clamp = lim_pos[pidaw_pkg::DRIVE_W-1:0];
        end else if (integ_sum < lim_neg) begin
            integ_clamp = lim_neg[pidaw_pkg::DRIVE_W-1:0];
        end else begin
            integ_clamp = integ_sum[pidaw_pkg::DRIVE_W-1:0];
        end
        dec_hit        = (d_reg < D_TRIG_Q) && (integ_clamp > I_TRIG_Q);
        integ_acc_next = dec_hit ? integ_clamp - DROP_Q : integ_clamp;
        drive_sum      = SUM_W'(p_reg) + SUM_W'(integ_acc_next) + SUM_W'(d_reg);
        if (drive_sum > DRIVE_MAX) begin
            drive_next = DRIVE_MAX[pidaw_pkg::DRIVE_W-1:0];
        end else if (drive_sum < DRIVE_MIN) begin
            drive_next = DRIVE_MIN[pidaw_pkg::DRIVE_W-1:0];
        end else begin
            drive_next = drive_sum[pidaw_pkg::DRIVE_W-1:0];
        end
    end

    // stage 3: servo mix
    always_comb begin
        sa_sum = CENTER_Q + SV_W'(drive_reg);
        sb_sum = CENTER_Q - SV_W'(drive_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg      <= 1'b0;
            v_prod_reg    <= 1'b0;
            v_drv_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            integ_acc_reg <= '0;
            prev_err_reg  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                v_in_reg <= 1'b1;
            end else if (adv_prod) begin
                v_in_reg <= 1'b0;
            end
            if (adv_prod) begin
                v_prod_reg   <= 1'b1;
                prev_err_reg <= err_val;
            end else if (adv_drv) begin
                v_prod_reg <= 1'b0;
            end
            if (adv_drv) begin
                v_drv_reg     <= 1'b1;
                integ_acc_reg <= integ_acc_next;
            end else if (adv_out) begin
                v_drv_reg <= 1'b0;
            end
            if (adv_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            meas_reg <= s_meas;
        end
        if (adv_prod) begin
            p_reg  <= P_W'(cfg.gain_p) * P_W'(err_val);
            ie_reg <= P_W'(cfg.gain_i) * P_W'(err_val);
            d_reg  <= D_W'(cfg.gain_d) * D_W'(diff_val);
        end
        if (adv_drv) begin
            drive_reg <= drive_next;
        end
        if (adv_out) begin
            drive_out_reg <= drive_reg;
            servo_a_reg   <= servo_sat(sa_sum);
            servo_b_reg   <= servo_sat(sb_sum);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_drive   = drive_out_reg;
    assign m_servo_a = servo_a_reg;
    assign m_servo_b = servo_b_reg;

    `PIDAW_ASSERT(a_accept_fills_input, s_valid && s_ready |=> v_in_reg)
    `PIDAW_ASSERT(a_prev_err_tracks, adv_prod |=> prev_err_reg == $past(err_val))
    `PIDAW_ASSERT(a_decrement_floor, adv_drv && dec_hit |=> integ_acc_reg > ONE_Q)
    `PIDAW_ASSERT(a_out_fills, adv_out |=> m_valid_reg)

endmodule

FILE: rtl/pid_antiwindup_servo_mix.sv
// ----------------------------------------------------------------------------
// pid_antiwindup_servo_mix
// PID controller with clamped integral and a two-servo output mix.
// ----------------------------------------------------------------------------
// Each item is one measurement; the block returns one item holding the
// saturated PID drive (signed Q.FRAC_BITS) and the two servo commands
// 1500 + drive and 1500 - drive as truncated, saturated integers. It takes
// one item per clock unless the output stalls, and its result item passes
// through the input register, the gain products, the integral update and
// drive sum, and the servo mix before it is presented.
// A held m_tready stalls the stages back to the input.
// The integral accumulator closes its loop inside the drive stage, which
// is what allows back-to-back items. Gains, setpoint and the integral bound
// are APB registers at 0x00, 0x04, 0x08, 0x0C and 0x10 and should be
// written while no item is in flight.
// ----------------------------------------------------------------------------
module pid_antiwindup_servo_mix #(
    parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // apb
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidaw_pkg::ADDR_W-1:0] paddr,
    input  logic [pidaw_pkg::APB_W-1:0]  pwdata,
    output logic [pidaw_pkg::APB_W-1:0]  prdata,
    output logic                         pready,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // measurement[15:0]
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [63:0]                  m_tdata    // drive_value[31:0], servo_a[47:32],
                                                    // servo_b[63:48]
);

    pidaw_pkg::cfg_t cfg;
    logic signed [pidaw_pkg::DRIVE_W-1:0] drive;
    logic signed [pidaw_pkg::SERVO_W-1:0] servo_a;
    logic signed [pidaw_pkg::SERVO_W-1:0] servo_b;

    assign pready = 1'b1;

    pidaw_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pidaw_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_meas    ($signed(s_tdata)),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_drive   (drive),
        .m_servo_a (servo_a),
        .m_servo_b (servo_b)
    );

    assign m_tdata = {servo_b, servo_a, drive};

endmodule
